// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the hasher modules.
// Each macro expands to one labeled concurrent assertion on clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`endif

// ===== hdl/sha256_pkg.sv =====
// Package for the SHA-256 message hasher: item types, constants, round table.
// Used by the controller, datapath and top level.
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned CountW = 61;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Datapath commands.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUT,
    CMD_START,
    CMD_LENGTH,
    CMD_CLEAR,
    CMD_RESET_CHAIN
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    logic [5:0] pos;
    logic [7:0] data;
  } dp_ctrl_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/sha256_dp.sv =====
// Datapath of the SHA-256 hasher: block buffer, schedule window, round unit, chain value.
// Depends on sha256_pkg; commanded by sha256_ctrl.
`timescale 1ns / 1ps

module sha256_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha256_pkg::dp_ctrl_t ctrl_i,
  input  logic [63:0]          bit_len_i,
  input  logic [2:0]           rd_idx_i,
  output logic [31:0]          rd_word_o,
  output sha256_pkg::dp_stat_t stat_o
);
  import sha256_pkg::*;

  logic [31:0] blk_q [16];
  logic [31:0] win_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [6:0]  rnd_q;
  logic        busy_q;
  logic        fold_q;

  logic [31:0] s0, s1, w_new, wt, t1, t2, big0, big1, ch, maj;

  // Schedule and round logic for the current round.
  always_comb begin
    wt    = win_q[0];
    s0    = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1    = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_new = s1 + win_q[9] + s0 + win_q[0];
    big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1    = v_q[7] + big1 + ch + RoundK[rnd_q[5:0]] + wt;
    big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = big0 + maj;
  end

  // Block buffer byte writes, padding clear and length insertion.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_PUT: begin
        if (ctrl_i.pos[1:0] == 2'd0) begin
          blk_q[ctrl_i.pos[5:2]] <= {ctrl_i.data, 24'd0};
        end else begin
          blk_q[ctrl_i.pos[5:2]][8 * (3 - ctrl_i.pos[1:0]) +: 8] <= ctrl_i.data;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < 16; i++) blk_q[i] <= '0;
      end
      CMD_LENGTH: begin
        blk_q[14] <= bit_len_i[63:32];
        blk_q[15] <= bit_len_i[31:0];
      end
      default: ;
    endcase
  end

  // Round sequencing, one round per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fold_q <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
    end else begin
      fold_q <= 1'b0;
      if (ctrl_i.cmd == CMD_RESET_CHAIN) begin
        for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
      end
      if (ctrl_i.cmd == CMD_START) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        for (int i = 0; i < 16; i++) win_q[i] <= blk_q[i];
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end else if (busy_q) begin
        for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
        win_q[15] <= w_new;
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        rnd_q  <= rnd_q + 7'd1;
        if (rnd_q == 7'd63) begin
          busy_q <= 1'b0;
          fold_q <= 1'b1;
        end
      end
      // Fold the working variables into the chain value.
      if (fold_q) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  assign rd_word_o   = h_q[rd_idx_i];
  assign stat_o.busy = busy_q | fold_q;

  `include "assert_macros.svh"
  `ASSERT_IMP(a_round_range, busy_q, rnd_q < 7'd64)
  `ASSERT_IMP(a_fold_after_last, fold_q, $past(rnd_q) == 7'd63)
  `ASSERT_IMP(a_no_start_busy, ctrl_i.cmd == CMD_START, !stat_o.busy)

endmodule

// ===== hdl/sha256_ctrl.sv =====
// Controller of the SHA-256 hasher: input handshake, padding sequence, digest output.
// Depends on sha256_pkg; drives sha256_dp through command signals.
`timescale 1ns / 1ps

module sha256_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha256_pkg::out_item_t out_item_o,
  output sha256_pkg::dp_ctrl_t  ctrl_o,
  output logic [63:0]           bit_len_o,
  output logic [2:0]            rd_idx_o,
  input  logic [31:0]           rd_word_i,
  input  sha256_pkg::dp_stat_t  stat_i
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_WAIT_BYTE, S_PAD, S_ZERO, S_MID, S_WAIT_MID,
    S_LEN, S_FINAL, S_WAIT_FINAL, S_OUT
  } state_e;

  state_e          state_q;
  logic [CountW-1:0] cnt_q;
  logic [5:0]      pos_q;
  logic            last_q;
  logic [2:0]      idx_q;
  logic            ov_q;
  dp_ctrl_t        ctrl_q;
  logic            take;

  assign in_stall_o = (state_q != S_IDLE);
  assign take       = in_valid_i && !in_stall_o;
  assign bit_len_o  = {cnt_q, 3'b000};
  assign rd_idx_o   = idx_q;
  assign ctrl_o     = ctrl_q;

  // Sequencer: byte intake, padding and output of the eight words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      ctrl_q  <= '{cmd: CMD_NONE, pos: '0, data: '0};
    end else begin
      ctrl_q <= '{cmd: CMD_NONE, pos: '0, data: '0};
      case (state_q)
        S_IDLE: begin
          if (take) begin
            last_q <= in_item_i.last_byte;
            if (in_item_i.byte_present) begin
              ctrl_q  <= '{cmd: CMD_PUT, pos: cnt_q[5:0], data: in_item_i.data_byte};
              cnt_q   <= cnt_q + 1'b1;
              state_q <= S_BYTE;
              pos_q   <= cnt_q[5:0];
            end else if (in_item_i.last_byte) begin
              state_q <= S_PAD;
            end
          end
        end
        S_BYTE: begin
          if (pos_q == 6'd63) begin
            ctrl_q  <= '{cmd: CMD_START, pos: '0, data: '0};
            state_q <= S_WAIT_BYTE;
          end else begin
            state_q <= last_q ? S_PAD : S_IDLE;
          end
        end
        S_WAIT_BYTE: begin
          // The datapath raises busy in the cycle after the start command.
          if (!stat_i.busy && ctrl_q.cmd != CMD_START) state_q <= last_q ? S_PAD : S_IDLE;
        end
        S_PAD: begin
          ctrl_q  <= '{cmd: CMD_PUT, pos: cnt_q[5:0], data: PadByte};
          pos_q   <= cnt_q[5:0] + 6'd1;
          state_q <= (cnt_q[5:0] == 6'd63) ? S_MID : S_ZERO;
        end
        S_ZERO: begin
          // Zero fill, one byte a cycle, to the end of the block.
          ctrl_q <= '{cmd: CMD_PUT, pos: pos_q, data: 8'h00};
          pos_q  <= pos_q + 6'd1;
          if (pos_q == 6'd63) state_q <= (cnt_q[5:0] >= LengthPos) ? S_MID : S_LEN;
        end
        S_MID: begin
          ctrl_q  <= '{cmd: CMD_START, pos: '0, data: '0};
          state_q <= S_WAIT_MID;
        end
        S_WAIT_MID: begin
          if (!stat_i.busy && ctrl_q.cmd != CMD_START) begin
            ctrl_q  <= '{cmd: CMD_CLEAR, pos: '0, data: '0};
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          ctrl_q  <= '{cmd: CMD_LENGTH, pos: '0, data: '0};
          state_q <= S_FINAL;
        end
        S_FINAL: begin
          ctrl_q  <= '{cmd: CMD_START, pos: '0, data: '0};
          state_q <= S_WAIT_FINAL;
        end
        S_WAIT_FINAL: begin
          if (!stat_i.busy && ctrl_q.cmd != CMD_START) begin
            idx_q   <= '0;
            ov_q    <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              ov_q    <= 1'b0;
              cnt_q   <= '0;
              ctrl_q  <= '{cmd: CMD_RESET_CHAIN, pos: '0, data: '0};
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o            = ov_q;
  assign out_item_o.digest_word = rd_word_i;
  assign out_item_o.word_index  = idx_q;
  assign out_item_o.last_word   = (idx_q == 3'd7);

  `include "assert_macros.svh"
  `ASSERT_IMP(a_out_only_in_out, out_valid_o, state_q == S_OUT)
  `ASSERT_IMP(a_no_take_busy, stat_i.busy, in_stall_o)
  `ASSERT_IMP(a_out_ends, out_valid_o && !out_stall_i && out_item_o.last_word,
              ##1 state_q == S_IDLE)

endmodule

// ===== hdl/sha256_message_hasher.sv =====
// SHA-256 message hasher top level.
// Input channel: one item per accepted valid/stall handshake, carrying one
// message byte (when byte_present is set) and an end mark (last_byte).
// Output channel: eight items per message, the digest words H0 first, each
// with its word_index, and with last_word set on the eighth.
// Item handling: an item with a byte is written into the block buffer and
// the input stalls in the byte state before the next item is taken. The item
// that completes a 64-byte block starts a compression: a load, 64 rounds
// at one a cycle and a fold. An end item pads the block one byte a cycle,
// runs one or two compressions, then presents the eight digest words.
// The input is stalled while padding, compressing and emitting.
// When the receiver stalls, the current digest word holds until taken.
// Reset clears the byte count and loads the initial hash values; the block
// buffer contents are undefined until written and need no clearing.
// After the eighth word is taken the block is ready for a new message.
`timescale 1ns / 1ps

module sha256_message_hasher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha256_pkg::out_item_t out_item_o
);
  import sha256_pkg::*;

  dp_ctrl_t    ctrl;
  dp_stat_t    stat;
  logic [63:0] bit_len;
  logic [2:0]  rd_idx;
  logic [31:0] rd_word;

  // Controller: handshakes and padding sequence.
  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .ctrl_o      (ctrl),
    .bit_len_o   (bit_len),
    .rd_idx_o    (rd_idx),
    .rd_word_i   (rd_word),
    .stat_i      (stat)
  );

  // Datapath: block buffer and compression rounds.
  sha256_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .bit_len_i (bit_len),
    .rd_idx_i  (rd_idx),
    .rd_word_o (rd_word),
    .stat_o    (stat)
  );

endmodule

// ===== sim/sha256_message_hasher_test.sv =====
// Testbench for the SHA-256 message hasher: random and directed messages,
// predicted digests checked word by word through a small scoreboard class.
// Depends on sha256_pkg and the sha256_message_hasher top level only.
`timescale 1ns / 1ps

module sha256_message_hasher_test;
  import sha256_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffCycles = 600;

  // Digest predictor and queue of expected digest words.
  class digest_board;
    logic [31:0] chain[8];
    logic [31:0] blk[16];
    logic [60:0] byte_count;
    out_item_t pending[$];
    int unsigned errors;

    function new();
      errors = 0;
      start_message();
    endfunction

    function void start_message();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      byte_count = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void place_byte(logic [5:0] pos, logic [7:0] b);
      if (pos[1:0] == 2'd0) begin
        blk[pos[5:2]] = {b, 24'h0};
      end else begin
        blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
      end
    endfunction

    // One 64-round compression of the current block into the chain.
    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++) begin
        w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
             + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // Note an accepted input item and queue any digest it completes.
    function void note_input(in_item_t it);
      logic [5:0] pos;
      logic [63:0] bits;
      out_item_t r;
      if (it.byte_present) begin
        pos = byte_count[5:0];
        place_byte(pos, it.data_byte);
        byte_count++;
        if (pos == 6'd63) compress();
      end
      if (!it.last_byte) return;
      pos = byte_count[5:0];
      place_byte(pos, PadByte);
      for (int i = pos + 1; i < 64; i++) place_byte(i[5:0], 8'h00);
      if (pos >= LengthPos) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {byte_count, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        r.digest_word = chain[i];
        r.word_index = i[2:0];
        r.last_word = (i == 7);
        pending = {pending, r};
      end
      start_message();
    endfunction

    // Compare one accepted output item with the oldest expectation.
    function void check_output(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest item %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.digest_word !== exp.digest_word)
        $display("%0t: digest_word expected %h actual %h", $time,
                 exp.digest_word, got.digest_word);
      if (got.word_index !== exp.word_index)
        $display("%0t: word_index expected %0d actual %0d", $time,
                 exp.word_index, got.word_index);
      if (got.last_word !== exp.last_word)
        $display("%0t: last_word expected %b actual %b", $time,
                 exp.last_word, got.last_word);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_item_t in_item_i;
  out_item_t out_item_o;

  digest_board board;
  bit calm;         // no idling on either side
  bit hold_off;     // receiver holds off for a long stretch
  int unsigned cycles;

  sha256_message_hasher dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one item and wait until it is taken, with random idle gaps first.
  // Valid stays high after the item is taken so items can follow back to back.
  task automatic send_item(logic [7:0] b, logic present, logic last);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_item_i <= '{data_byte: b, byte_present: present, last_byte: last};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(in_item_i);
    @(negedge clk_i);
  endtask

  // A whole message of random bytes; the end mark may share the last byte.
  task automatic send_message(int unsigned len);
    bit joined;
    joined = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(255)), 1'b1, joined && (i == len - 1));
    if (!joined) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Stop offering items and wait until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else if (hold_off) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_output(out_item_o);
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    board = new();
    cycles = 0;
    calm = 1'b0;
    hold_off = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b1;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty message, extreme bytes, padding boundaries.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    send_item(8'hab, 1'b1, 1'b1);
    wait_drained();
    // Pad byte in the last block position (extra block), then a full block.
    send_message(63);
    send_message(64);

    // Long receiver hold-off while the sender keeps offering items.
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_message(3);
        send_message(2);
      end
    join
    wait_drained();

    // Random short messages with a stretch without idling.
    for (int m = 0; m < 10; m++) begin
      calm = (m >= 3 && m < 8);
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_message($urandom_range(0, 6));
      if ($urandom_range(5) == 0) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (300) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
